// ----- rtl/tdv_pkg.sv -----
`timescale 1ns / 1ps

package tdv_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 48;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPECTED_VERSION   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIELD_COUNT_LIMIT  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VALUE_LENGTH_LIMIT = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WORD_TYPE_CODES    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BYTE_TYPE_CODE     = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ID_TYPE_CODE       = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REGION_TYPE_CODES  = 3'd6;

   localparam int WORD_CODE_COUNT   = 6;
   localparam int REGION_CODE_COUNT = 2;

   localparam logic [15:0] WORD_VALUE_LENGTH = 16'd4;
   localparam logic [15:0] BYTE_VALUE_LENGTH = 16'd1;
   localparam logic [15:0] ID_VALUE_LENGTH   = 16'd16;

   localparam logic [2:0] PHASE_HEADER = 3'd0;
   localparam logic [2:0] PHASE_RHDR   = 3'd1;
   localparam logic [2:0] PHASE_VALUE  = 3'd2;
   localparam logic [2:0] PHASE_DONE   = 3'd3;
   localparam logic [2:0] PHASE_ERROR  = 3'd4;

   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;
   localparam logic [1:0] POS_FOURTH = 2'd3;

   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_SHORT       = 3'd1;
   localparam logic [2:0] STATUS_VERSION     = 3'd2;
   localparam logic [2:0] STATUS_COUNT       = 3'd3;
   localparam logic [2:0] STATUS_HDR_TRUNC   = 3'd4;
   localparam logic [2:0] STATUS_TOO_LONG    = 3'd5;
   localparam logic [2:0] STATUS_VALUE_TRUNC = 3'd6;
   localparam logic [2:0] STATUS_BAD_LENGTH  = 3'd7;

   typedef struct packed {
      logic [7:0]  expected_version;
      logic [15:0] field_count_limit;
      logic [15:0] value_length_limit;
      logic [47:0] word_type_codes;
      logic [7:0]  byte_type_code;
      logic [7:0]  id_type_code;
      logic [15:0] region_type_codes;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      expected_version:   8'd1,
      field_count_limit:  16'd32,
      value_length_limit: 16'd256,
      word_type_codes:    48'h010203040506,
      byte_type_code:     8'd7,
      id_type_code:       8'd8,
      region_type_codes:  16'h090A
   };

   // word codes first, then byte, id, region; anything else passes
   function automatic logic length_ok(input cfg_type cfg, input logic [7:0] rtype,
                                      input logic [15:0] rlen);
      logic word_hit;
      logic region_hit;
      word_hit = 1'b0;
      region_hit = 1'b0;
      for (int i = 0; i < WORD_CODE_COUNT; i++) begin
         if (cfg.word_type_codes[8*i +: 8] == rtype) word_hit = 1'b1;
      end
      for (int i = 0; i < REGION_CODE_COUNT; i++) begin
         if (cfg.region_type_codes[8*i +: 8] == rtype) region_hit = 1'b1;
      end
      if (word_hit) return rlen == WORD_VALUE_LENGTH;
      if (rtype == cfg.byte_type_code) return rlen == BYTE_VALUE_LENGTH;
      if (rtype == cfg.id_type_code) return rlen == ID_VALUE_LENGTH;
      if (region_hit) return (rlen != 16'd0) && !rlen[0];
      return 1'b1;
   endfunction

endpackage

// ----- rtl/tlv_descriptor_validator.sv -----
`timescale 1ns / 1ps

// TLV descriptor validator.
// req_ channel: one buffer byte per transfer (req_data_byte), req_final_byte
// set on the last byte of a buffer. rsp_ channel: one rsp_status per buffer,
// sent only for the final byte; other bytes produce no transfer.
// csr_ port: write-only registers, written when csr_write_enable is high;
// write only while no buffer is in flight.
// Throughput: one byte per cycle while req_stall is low. A final byte passes
// through the input register, then the parse state update and result register,
// before its status shows on rsp_valid.
// Stall: a pending final byte waits in the input register while the result
// register holds an unaccepted status under rsp_stall; req_stall rises only
// then. Non-final bytes keep flowing under rsp_stall.
// Reset: synchronous, active high; clears the pipeline and parse state and
// loads register defaults (version 1, count limit 32, length limit 256,
// word codes 1..6, byte code 7, id code 8, region codes 9 and 10).
module tlv_descriptor_validator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_final_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_status,
   input  logic                                csr_write_enable,
   input  logic [tdv_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tdv_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import tdv_pkg::*;

   cfg_type cfg;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_final_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff;
   logic [2:0] core_status;
   logic       advance;
   logic       load;

   tdv_csr_regs u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   tdv_parse_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step       (advance),
      .data_byte  (in_byte_ff),
      .final_byte (in_final_ff),
      .status     (core_status)
   );

   assign advance   = in_valid_ff && !(in_final_ff && rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   assign in_valid_in  = load || (in_valid_ff && !advance);
   assign rsp_valid_in = (advance && in_final_ff) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_byte_ff  <= req_data_byte;
         in_final_ff <= req_final_byte;
      end
      if (advance && in_final_ff) begin
         rsp_status_ff <= core_status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   // a new status only comes from a final byte leaving the input register
   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff && in_final_ff))
      else $error("status produced without a final byte");

   // non-final bytes never back up the input side
   a_no_stall_nonfinal: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_final_ff) |-> !req_stall)
      else $error("stall on a non-final byte");

   // a stall only comes from a held status the receiver has not taken
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_final_ff && rsp_valid_ff && rsp_stall))
      else $error("input stall without a blocked result");

endmodule

// ----- rtl/tdv_csr_regs.sv -----
`timescale 1ns / 1ps

module tdv_csr_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [tdv_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [tdv_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   output tdv_pkg::cfg_type                     cfg
);
   import tdv_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_EXPECTED_VERSION:   cfg_in.expected_version   = csr_write_data[7:0];
            CSR_FIELD_COUNT_LIMIT:  cfg_in.field_count_limit  = csr_write_data[15:0];
            CSR_VALUE_LENGTH_LIMIT: cfg_in.value_length_limit = csr_write_data[15:0];
            CSR_WORD_TYPE_CODES:    cfg_in.word_type_codes    = csr_write_data[47:0];
            CSR_BYTE_TYPE_CODE:     cfg_in.byte_type_code     = csr_write_data[7:0];
            CSR_ID_TYPE_CODE:       cfg_in.id_type_code       = csr_write_data[7:0];
            CSR_REGION_TYPE_CODES:  cfg_in.region_type_codes  = csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/tdv_parse_core.sv -----
`timescale 1ns / 1ps

module tdv_parse_core (
   input  logic             clock,
   input  logic             reset,
   input  tdv_pkg::cfg_type cfg,
   input  logic             step,
   input  logic [7:0]       data_byte,
   input  logic             final_byte,
   output logic [2:0]       status
);
   import tdv_pkg::*;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  pos_ff, pos_in;
   logic [15:0] fields_ff, fields_in;
   logic [7:0]  rtype_ff, rtype_in;
   logic [15:0] rlen_ff, rlen_in;
   logic [15:0] left_ff, left_in;
   logic [2:0]  err_ff, err_in;

   logic [15:0] count;
   logic [15:0] full_len;
   logic [15:0] fields_dec;
   logic [15:0] left_dec;

   assign count      = {fields_ff[7:0], data_byte};
   assign full_len   = {rlen_ff[15:8], data_byte};
   assign fields_dec = fields_ff - 16'd1;
   assign left_dec   = left_ff - 16'd1;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      fields_in = fields_ff;
      rtype_in  = rtype_ff;
      rlen_in   = rlen_ff;
      left_in   = left_ff;
      err_in    = err_ff;
      status    = err_ff;

      case (phase_ff)
         PHASE_HEADER: begin
            case (pos_ff)
               POS_FIRST: begin
                  if (data_byte != cfg.expected_version) err_in = STATUS_VERSION;
                  pos_in = POS_SECOND;
               end
               POS_SECOND: pos_in = POS_THIRD;
               POS_THIRD: begin
                  fields_in = {8'd0, data_byte};
                  pos_in    = POS_FOURTH;
               end
               default: begin
                  pos_in = POS_FIRST;
                  if (err_ff != STATUS_OK) begin
                     phase_in = PHASE_ERROR;
                  end else if (count > cfg.field_count_limit) begin
                     err_in   = STATUS_COUNT;
                     phase_in = PHASE_ERROR;
                  end else begin
                     fields_in = count;
                     phase_in  = (count != 16'd0) ? PHASE_RHDR : PHASE_DONE;
                  end
               end
            endcase
         end
         PHASE_RHDR: begin
            case (pos_ff)
               POS_FIRST: begin
                  rtype_in = data_byte;
                  pos_in   = POS_SECOND;
               end
               POS_SECOND: begin
                  rlen_in = {data_byte, 8'd0};
                  pos_in  = POS_THIRD;
               end
               default: begin
                  rlen_in   = full_len;
                  pos_in    = POS_FIRST;
                  fields_in = fields_dec;
                  if (full_len > cfg.value_length_limit) begin
                     err_in   = STATUS_TOO_LONG;
                     phase_in = PHASE_ERROR;
                  end else if (full_len != 16'd0) begin
                     left_in  = full_len;
                     phase_in = PHASE_VALUE;
                  end else begin
                     left_in = 16'd0;
                     if (!length_ok(cfg, rtype_ff, full_len)) begin
                        err_in   = STATUS_BAD_LENGTH;
                        phase_in = PHASE_ERROR;
                     end else if (fields_dec == 16'd0) begin
                        phase_in = PHASE_DONE;
                     end else begin
                        phase_in = PHASE_RHDR;
                     end
                  end
               end
            endcase
         end
         PHASE_VALUE: begin
            left_in = left_dec;
            if (left_dec == 16'd0) begin
               if (!length_ok(cfg, rtype_ff, rlen_ff)) begin
                  err_in   = STATUS_BAD_LENGTH;
                  phase_in = PHASE_ERROR;
               end else if (fields_ff == 16'd0) begin
                  phase_in = PHASE_DONE;
               end else begin
                  phase_in = PHASE_RHDR;
                  pos_in   = POS_FIRST;
               end
            end
         end
         default: ;
      endcase

      case (phase_in)
         PHASE_HEADER: status = STATUS_SHORT;
         PHASE_RHDR:   status = STATUS_HDR_TRUNC;
         PHASE_VALUE:  status = STATUS_VALUE_TRUNC;
         PHASE_DONE:   status = STATUS_OK;
         default:      status = err_in;
      endcase

      if (final_byte) begin
         phase_in  = PHASE_HEADER;
         pos_in    = POS_FIRST;
         fields_in = 16'd0;
         rtype_in  = 8'd0;
         rlen_in   = 16'd0;
         left_in   = 16'd0;
         err_in    = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_HEADER;
         pos_ff    <= POS_FIRST;
         fields_ff <= 16'd0;
         rtype_ff  <= 8'd0;
         rlen_ff   <= 16'd0;
         left_ff   <= 16'd0;
         err_ff    <= STATUS_OK;
      end else if (step) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         fields_ff <= fields_in;
         rtype_ff  <= rtype_in;
         rlen_ff   <= rlen_in;
         left_ff   <= left_in;
         err_ff    <= err_in;
      end
   end

endmodule

// ----- tb/tlv_descriptor_validator_tb.sv -----
`timescale 1ns / 1ps

module tlv_descriptor_validator_tb;
   import tdv_pkg::*;

   localparam int CLOCK_PERIOD    = 4;
   localparam int RESET_CYCLES    = 9;
   localparam int MAX_WAIT        = 12;
   localparam int BYTES_PER_PHASE = 95;
   localparam int CONFIG_PHASES   = 7;
   localparam int SETTLE_CYCLES   = 6;
   localparam int HOLD_AFTER      = 20;
   localparam int HOLD_CYCLES     = 300;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int MAX_VALUE_BYTES = 24;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [7:0] data;
      logic       is_last;
   } stream_byte_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [7:0]                 req_data_byte = 8'd0;
   logic                       req_final_byte = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [2:0]                 rsp_status;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   // shadow registers and parse state
   cfg_type     cfg;
   logic [2:0]  prs_phase;
   logic [1:0]  prs_pos;
   logic [15:0] prs_fields;
   logic [7:0]  prs_type;
   logic [15:0] prs_len;
   logic [15:0] prs_left;
   logic [2:0]  prs_error;

   stream_byte_type byte_queue[$];
   logic [2:0]      status_due[$];
   logic [7:0]      build_bytes[$];
   stream_byte_type next_byte;
   logic [2:0]      due;

   logic send_idle_on = 1'b1;
   logic recv_idle_on = 1'b1;
   int   send_wait = 0;
   int   recv_wait = 0;
   int   hold_left = 0;
   int   results_seen = 0;
   int   error_count = 0;
   int   cycle_count = 0;
   int   bytes_queued = 0;
   int   phase_start;

   tlv_descriptor_validator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_final_byte   (req_final_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic logic length_fits(input logic [7:0] code, input logic [15:0] len);
      for (int i = 0; i < WORD_CODE_COUNT; i++) begin
         if (cfg.word_type_codes[8*i +: 8] == code) return len == WORD_VALUE_LENGTH;
      end
      if (code == cfg.byte_type_code) return len == BYTE_VALUE_LENGTH;
      if (code == cfg.id_type_code) return len == ID_VALUE_LENGTH;
      if (code == cfg.region_type_codes[7:0] || code == cfg.region_type_codes[15:8])
         return len != 16'd0 && !len[0];
      return 1'b1;
   endfunction

   function automatic logic [15:0] legal_length(input logic [7:0] code);
      for (int i = 0; i < WORD_CODE_COUNT; i++) begin
         if (cfg.word_type_codes[8*i +: 8] == code) return WORD_VALUE_LENGTH;
      end
      if (code == cfg.byte_type_code) return BYTE_VALUE_LENGTH;
      if (code == cfg.id_type_code) return ID_VALUE_LENGTH;
      if (code == cfg.region_type_codes[7:0] || code == cfg.region_type_codes[15:8])
         return 16'(2 * $urandom_range(1, 4));
      return 16'($urandom_range(0, 12));
   endfunction

   task automatic restart_parse();
      prs_phase  = PHASE_HEADER;
      prs_pos    = POS_FIRST;
      prs_fields = '0;
      prs_type   = '0;
      prs_len    = '0;
      prs_left   = '0;
      prs_error  = STATUS_OK;
   endtask

   task automatic close_record();
      if (!length_fits(prs_type, prs_len)) begin
         prs_error = STATUS_BAD_LENGTH;
         prs_phase = PHASE_ERROR;
      end else if (prs_fields == 16'd0) begin
         prs_phase = PHASE_DONE;
      end else begin
         prs_phase = PHASE_RHDR;
         prs_pos   = POS_FIRST;
      end
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic fin);
      logic [15:0] count;
      logic [2:0]  status;
      case (prs_phase)
         PHASE_HEADER: begin
            case (prs_pos)
               POS_FIRST: begin
                  if (b != cfg.expected_version) prs_error = STATUS_VERSION;
                  prs_pos = POS_SECOND;
               end
               POS_SECOND: prs_pos = POS_THIRD;
               POS_THIRD: begin
                  prs_fields = {8'd0, b};
                  prs_pos    = POS_FOURTH;
               end
               default: begin
                  count   = {prs_fields[7:0], b};
                  prs_pos = POS_FIRST;
                  if (prs_error != STATUS_OK) begin
                     prs_phase = PHASE_ERROR;
                  end else if (count > cfg.field_count_limit) begin
                     prs_error = STATUS_COUNT;
                     prs_phase = PHASE_ERROR;
                  end else begin
                     prs_fields = count;
                     prs_phase  = (count != 16'd0) ? PHASE_RHDR : PHASE_DONE;
                  end
               end
            endcase
         end
         PHASE_RHDR: begin
            case (prs_pos)
               POS_FIRST: begin
                  prs_type = b;
                  prs_pos  = POS_SECOND;
               end
               POS_SECOND: begin
                  prs_len = {b, 8'd0};
                  prs_pos = POS_THIRD;
               end
               default: begin
                  prs_len    = {prs_len[15:8], b};
                  prs_pos    = POS_FIRST;
                  prs_fields = prs_fields - 16'd1;
                  if (prs_len > cfg.value_length_limit) begin
                     prs_error = STATUS_TOO_LONG;
                     prs_phase = PHASE_ERROR;
                  end else begin
                     prs_left  = prs_len;
                     prs_phase = PHASE_VALUE;
                     if (prs_left == 16'd0) close_record();
                  end
               end
            endcase
         end
         PHASE_VALUE: begin
            prs_left = prs_left - 16'd1;
            if (prs_left == 16'd0) close_record();
         end
         default: ;
      endcase
      if (fin) begin
         case (prs_phase)
            PHASE_HEADER: status = STATUS_SHORT;
            PHASE_RHDR:   status = STATUS_HDR_TRUNC;
            PHASE_VALUE:  status = STATUS_VALUE_TRUNC;
            PHASE_DONE:   status = STATUS_OK;
            default:      status = prs_error;
         endcase
         status_due.push_back(status);
         restart_parse();
      end
   endtask

   task automatic queue_buffer();
      for (int i = 0; i < build_bytes.size(); i++) begin
         byte_queue.push_back('{data: build_bytes[i], is_last: i == build_bytes.size() - 1});
      end
      bytes_queued += build_bytes.size();
      build_bytes.delete();
   endtask

   task automatic queue_bytes(input logic [7:0] bytes[$]);
      build_bytes = bytes;
      queue_buffer();
   endtask

   // mostly well-formed descriptors; some bad versions, counts, lengths and cut-offs
   task automatic make_random_buffer();
      int count;
      int records;
      int pick;
      int len;
      int cut;
      int slot;
      logic [7:0] code;
      build_bytes.delete();
      build_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : cfg.expected_version);
      build_bytes.push_back(8'($urandom));
      pick = $urandom_range(0, 19);
      if (pick == 0)
         count = $urandom_range(0, 65535);
      else if (pick == 1 && cfg.field_count_limit != 16'hFFFF)
         count = $urandom_range(int'(cfg.field_count_limit) + 1, 65535);
      else
         count = $urandom_range(0, (cfg.field_count_limit < 16'd3) ? cfg.field_count_limit : 3);
      build_bytes.push_back(count[15:8]);
      build_bytes.push_back(count[7:0]);
      records = (count <= 6) ? count : $urandom_range(0, 6);
      for (int r = 0; r < records; r++) begin
         case ($urandom_range(0, 5))
            0: begin
               slot = $urandom_range(0, WORD_CODE_COUNT - 1);
               code = cfg.word_type_codes[8*slot +: 8];
            end
            1: code = cfg.byte_type_code;
            2: code = cfg.id_type_code;
            3: begin
               slot = $urandom_range(0, REGION_CODE_COUNT - 1);
               code = cfg.region_type_codes[8*slot +: 8];
            end
            default: code = 8'($urandom);
         endcase
         pick = $urandom_range(0, 9);
         if (pick == 0) len = $urandom_range(0, 20);
         else if (pick == 1) len = $urandom_range(0, 65535);
         else len = int'(legal_length(code));
         build_bytes.push_back(code);
         build_bytes.push_back(len[15:8]);
         build_bytes.push_back(len[7:0]);
         for (int v = 0; v < len && v < MAX_VALUE_BYTES; v++) build_bytes.push_back(8'($urandom));
         if (len > MAX_VALUE_BYTES) break;
      end
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 4)) build_bytes.push_back(8'($urandom));
      end
      if ($urandom_range(0, 5) == 0) begin
         cut = $urandom_range(1, build_bytes.size());
         while (build_bytes.size() > cut) void'(build_bytes.pop_back());
      end
      queue_buffer();
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value, input int width);
      logic [CSR_DATA_WIDTH-1:0] junk;
      junk = {16'($urandom), $urandom};
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= (junk << width) | value;
   endtask

   task automatic set_config(input int p);
      cfg_type plan;
      if (p == 1) begin
         plan = '0;
      end else if (p == 2) begin
         plan = '1;
      end else begin
         plan.expected_version  = 8'($urandom);
         plan.field_count_limit = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                  16'($urandom_range(0, 6));
         case ($urandom_range(0, 2))
            0:       plan.value_length_limit = 16'($urandom_range(0, 20));
            1:       plan.value_length_limit = 16'($urandom_range(16, 300));
            default: plan.value_length_limit = 16'($urandom);
         endcase
         for (int i = 0; i < WORD_CODE_COUNT; i++)
            plan.word_type_codes[8*i +: 8] = 8'($urandom_range(0, 12));
         plan.byte_type_code = 8'($urandom_range(0, 12));
         plan.id_type_code   = 8'($urandom_range(0, 12));
         for (int i = 0; i < REGION_CODE_COUNT; i++)
            plan.region_type_codes[8*i +: 8] = 8'($urandom_range(0, 12));
      end
      write_reg(CSR_EXPECTED_VERSION, CSR_DATA_WIDTH'(plan.expected_version), 8);
      write_reg(CSR_FIELD_COUNT_LIMIT, CSR_DATA_WIDTH'(plan.field_count_limit), 16);
      write_reg(CSR_VALUE_LENGTH_LIMIT, CSR_DATA_WIDTH'(plan.value_length_limit), 16);
      write_reg(CSR_WORD_TYPE_CODES, plan.word_type_codes, 48);
      write_reg(CSR_BYTE_TYPE_CODE, CSR_DATA_WIDTH'(plan.byte_type_code), 8);
      write_reg(CSR_ID_TYPE_CODE, CSR_DATA_WIDTH'(plan.id_type_code), 8);
      write_reg(CSR_REGION_TYPE_CODES, CSR_DATA_WIDTH'(plan.region_type_codes), 16);
      if (p == 3) write_reg(CSR_UNUSED, {16'($urandom), $urandom}, 48);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg = plan;
      @(negedge clock);
   endtask

   task automatic drain();
      while (byte_queue.size() != 0 || req_valid || status_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_byte(req_data_byte, req_final_byte);
            send_wait = send_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
         end
         if (!req_valid || !req_stall) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (byte_queue.size() != 0) begin
               next_byte = byte_queue.pop_front();
               req_valid      <= 1'b1;
               req_data_byte  <= next_byte.data;
               req_final_byte <= next_byte.is_last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (status_due.size() == 0) begin
               $error("rsp_status %0d transfer with none outstanding", rsp_status);
               error_count++;
            end else begin
               due = status_due.pop_front();
               if (rsp_status !== due) begin
                  $error("rsp_status mismatch: expected %0d, actual %0d", due, rsp_status);
                  error_count++;
               end
            end
            results_seen++;
            recv_wait = recv_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            // long hold-off so final bytes back up into the input
            if (results_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (recv_wait > 0) begin
            if (rsp_valid) recv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tlv_descriptor_validator verification failed");
         $finish;
      end
   end

   initial begin
      cfg = CFG_RESET;
      restart_parse();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_bytes('{8'h01});
      queue_bytes('{8'h05, 8'h00});
      queue_bytes('{8'h01, 8'h00, 8'h00, 8'h00});
      queue_bytes('{8'h02, 8'h00, 8'hFF, 8'hFF});
      queue_bytes('{8'h01, 8'h00, 8'h00, 8'h21});
      queue_bytes('{8'h01, 8'h80, 8'h00, 8'h01, 8'h07});
      queue_bytes('{8'h01, 8'h00, 8'h00, 8'h02, 8'h07, 8'h00, 8'h01, 8'hAB,
                    8'h03, 8'h00, 8'h04, 8'hDE, 8'hAD, 8'hBE, 8'hEF});
      queue_bytes('{8'h01, 8'h00, 8'h00, 8'h01, 8'h09, 8'h00, 8'h03, 8'h11, 8'h22, 8'h33});
      queue_bytes('{8'h01, 8'h00, 8'h00, 8'h01, 8'h08, 8'h00, 8'h10,
                    8'h01, 8'h02, 8'h03, 8'h04, 8'h05});
      queue_bytes('{8'h01, 8'h00, 8'h00, 8'h01, 8'h20, 8'h01, 8'h01});
      queue_bytes('{8'h01, 8'h00, 8'h00, 8'h01, 8'h0A, 8'h00, 8'h00, 8'h55, 8'h66});
      queue_bytes('{8'h01, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h77, 8'h88});
      drain();

      for (int p = 0; p <= CONFIG_PHASES; p++) begin
         if (p != 0) set_config(p);
         send_idle_on = (p % 3) != 1;
         recv_idle_on = (p % 3) != 2;
         if (p == 1) begin
            queue_bytes('{8'h00, 8'h00, 8'h00, 8'h00});
            queue_bytes('{8'h00, 8'h00, 8'h00, 8'h01});
         end
         if (p == 2) begin
            queue_bytes('{8'hFF, 8'h00, 8'hFF, 8'hFF});
            queue_bytes('{8'hFF, 8'h00, 8'h00, 8'h01, 8'h55, 8'hFF, 8'hFF, 8'h01, 8'h02});
         end
         phase_start = bytes_queued;
         while (bytes_queued - phase_start < BYTES_PER_PHASE) make_random_buffer();
         drain();
      end

      if (error_count == 0 && status_due.size() == 0) begin
         $display("tlv_descriptor_validator verification clean");
      end else begin
         $display("tlv_descriptor_validator verification failed");
      end
      $finish;
   end

endmodule
